// ===== rtl/xsf_pkg.sv =====
// Shared types and constants for the XOR sprite framebuffer.
// Request and response payloads, store command bundle, action codes, register map.
// No dependencies.
package xsf_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 64;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	localparam logic [7:0] WIDTH_RST  = 8'd64;
	localparam logic [6:0] HEIGHT_RST = 7'd32;
	localparam logic [7:0] WIDTH_MAX  = 8'(MAX_WIDTH);
	localparam logic [6:0] HEIGHT_MAX = 7'(MAX_HEIGHT);

	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;

	localparam logic [2:0] ACT_SPRITE = 3'd0;
	localparam logic [2:0] ACT_TOGGLE = 3'd1;
	localparam logic [2:0] ACT_READ   = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_DOWN   = 3'd4;
	localparam logic [2:0] ACT_LEFT   = 3'd5;
	localparam logic [2:0] ACT_RIGHT  = 3'd6;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		logic [7:0] sprite_byte;
		logic [7:0] shift_count;
	} req_t;

	typedef struct packed {
		logic collision;
		logic pixel_value;
	} rsp_t;

	typedef struct packed {
		logic                  rd_en;
		logic [COL_W-1:0]      rd_addr;
		logic                  wr_en;
		logic [COL_W-1:0]      wr_addr;
		logic [MAX_HEIGHT-1:0] wr_data;
		logic                  wipe;
	} mem_cmd_t;

	function automatic logic [7:0] clamp_width(input logic [7:0] v);
		logic [7:0] r;
		if (v == 8'd0)
			r = 8'd1;
		else if (v > WIDTH_MAX)
			r = WIDTH_MAX;
		else
			r = v;
		return r;
	endfunction

	function automatic logic [6:0] clamp_height(input logic [6:0] v);
		logic [6:0] r;
		if (v == 7'd0)
			r = 7'd1;
		else if (v > HEIGHT_MAX)
			r = HEIGHT_MAX;
		else
			r = v;
		return r;
	endfunction

endpackage

// ===== rtl/xor_sprite_framebuffer_core.sv =====
// Channel  Direction  Handshake                 Payload
// req      in         req_valid / req_ready     req_t (action, x_pos, y_pos, sprite_byte,
//                                               shift_count)
// rsp      out        rsp_valid / rsp_ready     rsp_t (collision, pixel_value)
// cfg      in         APB psel/penable/pwrite   active_width at 0x0, active_height at 0x4
//
// One request at a time. The 8-step remainder unit and the single memory read port set
// how long each request takes.
// A new request is taken while the previous response waits in the output register.
// Reset clears the store at once through per-column valid flags; a register write or
// a clear does the same. Depends on xsf_pkg, xsf_mod_unit, xsf_store.
module xor_sprite_framebuffer_core import xsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DECODE = 9'b000000010,
		S_MOD    = 9'b000000100,
		S_PIX_RD = 9'b000001000,
		S_PIX_WR = 9'b000010000,
		S_SPR_RD = 9'b000100000,
		S_SPR_WR = 9'b001000000,
		S_WALK   = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [7:0]       width_q;
	logic [6:0]       height_q;
	req_t             req_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [2:0]       idx_q;
	logic [7:0]       j_q;
	logic             coll_q;
	logic             pix_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             step_v_s1;
	logic [COL_W-1:0] dest_s1;
	logic             zero_s1;

	logic                  cfg_wr;
	logic                  mod_start;
	logic                  mod_done;
	logic [COL_W-1:0]      x_mod;
	logic [ROW_W-1:0]      y_mod;
	mem_cmd_t              cmd;
	logic [MAX_HEIGHT-1:0] rd_data;
	logic [MAX_HEIGHT-1:0] row_bit;
	logic [MAX_HEIGHT-1:0] row_mask;
	logic                  old_bit;
	logic [COL_W-1:0]      col_next;
	logic                  spr_last;
	logic                  spr_hit;
	logic                  walk_issue;
	logic [COL_W-1:0]      walk_src;
	logic [COL_W-1:0]      walk_dest;
	logic                  walk_zero;
	logic [8:0]            left_src;
	logic [7:0]            right_dest;
	logic [7:0]            right_src;
	logic                  big_down;
	logic                  big_side;
	logic                  coll_set;
	logic                  coll_load;
	logic                  pix_load;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			if (paddr == ADDR_WIDTH)
				width_q <= clamp_width(pwdata[7:0]);
			else if (paddr == ADDR_HEIGHT)
				height_q <= clamp_height(pwdata[6:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_WIDTH)
			prdata = {24'd0, width_q};
		else if (paddr == ADDR_HEIGHT)
			prdata = {25'd0, height_q};
	end

	xsf_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x_in   (req_q.x_pos),
		.y_in   (req_q.y_pos),
		.width  (width_q),
		.height (height_q),
		.done   (mod_done),
		.x_mod  (x_mod),
		.y_mod  (y_mod)
	);

	xsf_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_data (rd_data)
	);

	assign row_bit = {{(MAX_HEIGHT-1){1'b0}}, 1'b1} << row_q;
	// a height of 64 shifts the one out and the subtraction yields all ones
	assign row_mask = ({{(MAX_HEIGHT-1){1'b0}}, 1'b1} << height_q) - {{(MAX_HEIGHT-1){1'b0}}, 1'b1};
	assign old_bit  = |(rd_data & row_bit);
	assign col_next = (({1'b0, col_q} + 8'd1) == width_q) ? '0 : col_q + 1'b1;
	assign spr_last = (idx_q == 3'd7);
	assign spr_hit  = req_q.sprite_byte[3'd7 - idx_q];
	assign big_down = (req_q.shift_count >= {1'b0, height_q});
	assign big_side = (req_q.shift_count >= width_q);

	// source and destination of the current column step
	assign left_src   = {1'b0, j_q} + {1'b0, req_q.shift_count};
	assign right_dest = width_q - 8'd1 - j_q;
	assign right_src  = right_dest - req_q.shift_count;
	assign walk_issue = (state_q == S_WALK) && (j_q < width_q);

	always_comb begin
		walk_src  = j_q[COL_W-1:0];
		walk_dest = j_q[COL_W-1:0];
		walk_zero = 1'b0;
		if (req_q.action == ACT_LEFT) begin
			walk_src  = left_src[COL_W-1:0];
			walk_zero = (left_src >= {1'b0, width_q});
		end else if (req_q.action == ACT_RIGHT) begin
			walk_src  = right_src[COL_W-1:0];
			walk_dest = right_dest[COL_W-1:0];
			walk_zero = (right_dest < req_q.shift_count);
		end
	end

	always_comb begin
		state_d   = state_q;
		mod_start = 1'b0;
		cmd       = '0;
		coll_set  = 1'b0;
		coll_load = 1'b0;
		pix_load  = 1'b0;
		cmd.wipe  = cfg_wr;
		// write side of the column walk, in the cycle after its read
		if (step_v_s1) begin
			cmd.wr_en   = 1'b1;
			cmd.wr_addr = dest_s1;
			if (zero_s1)
				cmd.wr_data = '0;
			else if (req_q.action == ACT_DOWN)
				cmd.wr_data = (rd_data << req_q.shift_count[ROW_W-1:0]) & row_mask;
			else
				cmd.wr_data = rd_data;
		end
		unique case (state_q)
			S_IDLE: begin
				if (req_valid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_FIN;
				unique case (req_q.action)
					ACT_SPRITE, ACT_TOGGLE, ACT_READ: begin
						mod_start = 1'b1;
						state_d   = S_MOD;
					end
					ACT_CLEAR: cmd.wipe = 1'b1;
					ACT_DOWN: begin
						if (big_down)
							cmd.wipe = 1'b1;
						else if (req_q.shift_count != 8'd0)
							state_d = S_WALK;
					end
					ACT_LEFT, ACT_RIGHT: begin
						if (big_side)
							cmd.wipe = 1'b1;
						else if (req_q.shift_count != 8'd0)
							state_d = S_WALK;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_MOD: begin
				if (mod_done)
					state_d = (req_q.action == ACT_SPRITE) ? S_SPR_RD : S_PIX_RD;
			end
			S_PIX_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = col_q;
				state_d     = S_PIX_WR;
			end
			S_PIX_WR: begin
				if (req_q.action == ACT_TOGGLE) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = col_q;
					cmd.wr_data = rd_data ^ row_bit;
					coll_load   = 1'b1;
				end else begin
					pix_load = 1'b1;
				end
				state_d = S_FIN;
			end
			S_SPR_RD: begin
				if (spr_hit) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = col_q;
					state_d     = S_SPR_WR;
				end else if (spr_last) begin
					state_d = S_FIN;
				end
			end
			S_SPR_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = col_q;
				cmd.wr_data = rd_data ^ row_bit;
				coll_set    = old_bit;
				state_d     = spr_last ? S_FIN : S_SPR_RD;
			end
			S_WALK: begin
				if (walk_issue) begin
					cmd.rd_en   = !walk_zero;
					cmd.rd_addr = walk_src;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			step_v_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			step_v_s1 <= walk_issue;
			if (state_q == S_FIN && (!rsp_valid_q || rsp_ready))
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid)
			req_q <= req;
		if (state_q == S_DECODE) begin
			coll_q <= 1'b0;
			pix_q  <= 1'b0;
			j_q    <= 8'd0;
		end
		if (state_q == S_MOD && mod_done) begin
			col_q <= x_mod;
			row_q <= y_mod;
			idx_q <= 3'd0;
		end
		// advance to the next sprite pixel after a skip or a write
		if ((state_q == S_SPR_RD && !spr_hit) || state_q == S_SPR_WR) begin
			idx_q <= idx_q + 3'd1;
			col_q <= col_next;
		end
		if (coll_set)
			coll_q <= 1'b1;
		if (coll_load)
			coll_q <= old_bit;
		if (pix_load)
			pix_q <= old_bit;
		if (walk_issue) begin
			j_q     <= j_q + 8'd1;
			dest_s1 <= walk_dest;
			zero_s1 <= walk_zero;
		end
		if (state_q == S_FIN && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.collision   <= coll_q;
			rsp_q.pixel_value <= pix_q;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/xsf_mod_unit.sv =====
// Iterative remainder unit: x mod width and y mod height, one quotient bit per cycle.
// Depends on xsf_pkg.
module xsf_mod_unit import xsf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [7:0]       x_in,
	input  logic [7:0]       y_in,
	input  logic [7:0]       width,
	input  logic [6:0]       height,
	output logic             done,
	output logic [COL_W-1:0] x_mod,
	output logic [ROW_W-1:0] y_mod
);

	logic       busy_q;
	logic       done_q;
	logic [2:0] k_q;
	logic [7:0] rx_q;
	logic [7:0] ry_q;
	logic [7:0] dw_q;
	logic [6:0] dh_q;
	logic [15:0] dx;
	logic [15:0] dy;

	assign dx = {8'd0, dw_q} << k_q;
	assign dy = {9'd0, dh_q} << k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= 3'd7;
			end else if (busy_q) begin
				k_q <= k_q - 3'd1;
				if (k_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rx_q <= x_in;
			ry_q <= y_in;
			dw_q <= width;
			dh_q <= height;
		end else if (busy_q) begin
			// subtract the shifted divisor where it fits
			if ({8'd0, rx_q} >= dx)
				rx_q <= rx_q - dx[7:0];
			if ({8'd0, ry_q} >= dy)
				ry_q <= ry_q - dy[7:0];
		end
	end

	assign done  = done_q;
	assign x_mod = rx_q[COL_W-1:0];
	assign y_mod = ry_q[ROW_W-1:0];

endmodule

// ===== rtl/xsf_store.sv =====
// Column store: one 64-bit word per column, one read and one write port, registered read.
// Per-column valid flags clear the whole store on a wipe. Depends on xsf_pkg.
module xsf_store import xsf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mem_cmd_t              cmd,
	output logic [MAX_HEIGHT-1:0] rd_data
);

	logic [MAX_HEIGHT-1:0] mem [MAX_WIDTH];
	logic [MAX_WIDTH-1:0]  valid_q;
	logic [MAX_HEIGHT-1:0] data_s1;
	logic                  vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[cmd.wr_addr] <= cmd.wr_data;
		if (cmd.rd_en)
			data_s1 <= mem[cmd.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (cmd.wipe)
				valid_q <= '0;
			else if (cmd.wr_en)
				valid_q[cmd.wr_addr] <= 1'b1;
			if (cmd.rd_en)
				vld_s1 <= valid_q[cmd.rd_addr];
		end
	end

	// a column never written since the last wipe reads dark
	assign rd_data = vld_s1 ? data_s1 : '0;

endmodule

// ===== verif/xor_sprite_framebuffer_core_tb.sv =====
// Self-checking bench for xor_sprite_framebuffer_core: random and directed requests,
// APB resizes between phases, responses checked against a local framebuffer model.
// Depends on xsf_pkg and the core RTL.
module xor_sprite_framebuffer_core_tb;
	import xsf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 5000;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_ITEMS = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// local copy of the display
	logic [MAX_HEIGHT-1:0] fb_cols [MAX_WIDTH];
	int fb_w = 64;
	int fb_h = 32;

	req_t req_pending [$];
	rsp_t rsp_expected [$];
	rsp_t mon_want;
	int   n_pushed = 0;
	int   n_done = 0;
	int   err_count = 0;
	int   stall_cycles = 0;
	int   send_idle = 0;
	int   recv_idle = 0;

	xor_sprite_framebuffer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int dim_clamp(input int v, input int top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic void fb_wipe();
		for (int i = 0; i < MAX_WIDTH; i++)
			fb_cols[i] = '0;
	endfunction

	// Apply one request to the local display and return its response.
	function automatic rsp_t apply_action(input req_t r);
		rsp_t                  o;
		logic [MAX_HEIGHT-1:0] pix;
		logic [MAX_HEIGHT-1:0] mask;
		int                    col;
		int                    c;
		int                    cnt;
		o = '0;
		col = int'(r.x_pos) % fb_w;
		pix = {{(MAX_HEIGHT-1){1'b0}}, 1'b1} << (int'(r.y_pos) % fb_h);
		mask = (fb_h >= MAX_HEIGHT) ? '1 : ({{(MAX_HEIGHT-1){1'b0}}, 1'b1} << fb_h) - 1'b1;
		cnt = int'(r.shift_count);
		case (r.action)
			ACT_SPRITE: begin
				for (int i = 0; i < 8; i++) begin
					if (r.sprite_byte[7-i]) begin
						c = (int'(r.x_pos) + i) % fb_w;
						if ((fb_cols[c] & pix) != '0)
							o.collision = 1'b1;
						fb_cols[c] ^= pix;
					end
				end
			end
			ACT_TOGGLE: begin
				fb_cols[col] ^= pix;
				o.collision = ((fb_cols[col] & pix) == '0);
			end
			ACT_READ: begin
				o.pixel_value = ((fb_cols[col] & pix) != '0);
			end
			ACT_CLEAR: begin
				fb_wipe();
			end
			ACT_DOWN: begin
				for (int i = 0; i < fb_w; i++)
					fb_cols[i] = (cnt >= fb_h) ? '0 : ((fb_cols[i] << cnt) & mask);
			end
			ACT_LEFT: begin
				if (cnt >= fb_w) begin
					fb_wipe();
				end else begin
					for (int i = 0; i < fb_w; i++)
						fb_cols[i] = (i + cnt < fb_w) ? fb_cols[i + cnt] : '0;
				end
			end
			ACT_RIGHT: begin
				if (cnt >= fb_w) begin
					fb_wipe();
				end else begin
					for (int i = fb_w; i > cnt; i--)
						fb_cols[i-1] = fb_cols[i-1-cnt];
					for (int i = 0; i < cnt; i++)
						fb_cols[i] = '0;
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic void queue_item(input logic [2:0] act, input int x, input int y,
			input int spr, input int cnt);
		req_t r;
		r.action = act;
		r.x_pos = 8'(x);
		r.y_pos = 8'(y);
		r.sprite_byte = 8'(spr);
		r.shift_count = 8'(cnt);
		req_pending.push_back(r);
		n_pushed++;
	endfunction

	// Mostly in-range coordinates and short scrolls; some full-range values.
	function automatic req_t rand_item();
		req_t r;
		int   pick;
		int   dim;
		pick = $urandom_range(99);
		if (pick < 30)
			r.action = ACT_SPRITE;
		else if (pick < 45)
			r.action = ACT_TOGGLE;
		else if (pick < 70)
			r.action = ACT_READ;
		else if (pick < 73)
			r.action = ACT_CLEAR;
		else if (pick < 81)
			r.action = ACT_DOWN;
		else if (pick < 89)
			r.action = ACT_LEFT;
		else if (pick < 97)
			r.action = ACT_RIGHT;
		else
			r.action = ACT_UNUSED;
		r.x_pos = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(fb_w - 1));
		r.y_pos = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(fb_h - 1));
		r.sprite_byte = 8'($urandom);
		dim = (r.action == ACT_DOWN) ? fb_h : fb_w;
		r.shift_count = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(dim));
		return r;
	endfunction

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_WIDTH)
			fb_w = dim_clamp(int'(data[7:0]), MAX_WIDTH);
		else if (addr == ADDR_HEIGHT)
			fb_h = dim_clamp(int'(data[6:0]), MAX_HEIGHT);
		fb_wipe();
	endtask

	task automatic drain();
		while (n_done < n_pushed)
			@(posedge clk);
	endtask

	// Request driver: predict at acceptance, then load the next request or drop valid.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				rsp_expected.push_back(apply_action(req));
			if (!req_valid || req_ready) begin
				if (req_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
					req <= req_pending.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor
	always @(posedge clk) begin
		if (arst_n) begin
			rsp_ready <= ($urandom_range(99) >= recv_idle);
			if (rsp_valid && rsp_ready) begin
				n_done++;
				if (rsp_expected.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("unexpected response: collision=%0b pixel_value=%0b",
							rsp.collision, rsp.pixel_value);
				end else begin
					mon_want = rsp_expected.pop_front();
					if (rsp.collision !== mon_want.collision ||
							rsp.pixel_value !== mon_want.pixel_value) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("mismatch at response %0d: collision exp %0b got %0b, %s%0b got %0b",
								n_done, mon_want.collision, rsp.collision,
								"pixel_value exp ", mon_want.pixel_value, rsp.pixel_value);
					end
				end
			end
		end
	end

	// Watchdog: count cycles with work outstanding and no handshake.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || n_done == n_pushed) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL xor_sprite_framebuffer_core");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [7:0] cfg_w [6];
		logic [6:0] cfg_h [6];
		cfg_w = '{8'd255, 8'd0, 8'd37, 8'd128, 8'd8, 8'd100};
		cfg_h = '{7'd100, 7'd0, 7'd64, 7'd13, 7'd8, 7'd45};
		fb_wipe();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 20;
		recv_idle = 54;

		// directed pass at reset size 64 x 32
		queue_item(ACT_SPRITE, 0, 0, 8'hFF, 0);
		queue_item(ACT_SPRITE, 0, 0, 8'hFF, 0);
		queue_item(ACT_SPRITE, 60, 255, 8'hA5, 0);
		queue_item(ACT_SPRITE, 255, 0, 8'h00, 0);
		queue_item(ACT_TOGGLE, 255, 255, 0, 0);
		queue_item(ACT_TOGGLE, 255, 255, 0, 0);
		queue_item(ACT_TOGGLE, 3, 4, 0, 0);
		queue_item(ACT_READ, 3, 4, 0, 0);
		queue_item(ACT_READ, 4, 4, 0, 0);
		queue_item(ACT_DOWN, 0, 0, 0, 0);
		queue_item(ACT_DOWN, 0, 0, 0, 5);
		queue_item(ACT_READ, 3, 9, 0, 0);
		queue_item(ACT_RIGHT, 0, 0, 0, 2);
		queue_item(ACT_READ, 5, 9, 0, 0);
		queue_item(ACT_LEFT, 0, 0, 0, 1);
		queue_item(ACT_RIGHT, 0, 0, 0, 64);
		queue_item(ACT_DOWN, 0, 0, 0, 32);
		queue_item(ACT_SPRITE, 250, 31, 8'hFF, 0);
		queue_item(ACT_LEFT, 0, 0, 0, 255);
		queue_item(ACT_SPRITE, 7, 7, 8'h81, 0);
		queue_item(ACT_DOWN, 0, 0, 0, 255);
		queue_item(ACT_CLEAR, 0, 0, 0, 0);
		queue_item(ACT_UNUSED, 255, 255, 8'hFF, 255);
		queue_item(ACT_READ, 0, 0, 0, 0);
		drain();

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				send_idle = 54;
				recv_idle = 20;
			end else if (p == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			// upper data bits are ignored by the registers
			cfg_write(ADDR_WIDTH, ($urandom() & 32'hFFFF_FF00) | 32'(cfg_w[p]));
			cfg_write(ADDR_HEIGHT, ($urandom() & 32'hFFFF_FF80) | 32'(cfg_h[p]));
			repeat (2) @(posedge clk);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				req_pending.push_back(rand_item());
				n_pushed++;
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (err_count == 0 && rsp_expected.size() == 0)
			$display("PASS xor_sprite_framebuffer_core");
		else
			$display("FAIL xor_sprite_framebuffer_core");
		$finish;
	end

endmodule
